FILE: src/tcw_pkg.sv
package tcw_pkg;

	localparam int ROWS_DEF = 25;
	localparam int COLS_DEF = 80;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE   = 8'd10;
	localparam logic [7:0] SPACE_CODE     = 8'd32;
	localparam logic [7:0] BLANK_ATTR_RST = 8'h0F;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  char_code;
		logic [7:0]  attr;
		logic [10:0] cell_index;
	} tcw_req_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [7:0]  read_char;
		logic [7:0]  read_attr;
		logic        scrolled;
	} tcw_rsp_t;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] chr;
	} tcw_cell_t;

endpackage

FILE: src/tcw_screen_ram.sv
module tcw_screen_ram #(
	parameter int DEPTH = tcw_pkg::ROWS_DEF * tcw_pkg::COLS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output tcw_pkg::tcw_cell_t rd_data,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  tcw_pkg::tcw_cell_t wr_data
);

	tcw_pkg::tcw_cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data is held until the next read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/tcw_seq.sv
module tcw_seq #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF,
	localparam int AW = $clog2(ROWS * COLS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  tcw_pkg::tcw_req_t  req,
	input  logic [7:0]         blank_attr,
	output logic               res_valid,
	input  logic               res_ready,
	output tcw_pkg::tcw_rsp_t  res,
	output logic               mem_rd_en,
	output logic [AW-1:0]      mem_rd_addr,
	input  tcw_pkg::tcw_cell_t mem_rd_data,
	output logic               mem_wr_en,
	output logic [AW-1:0]      mem_wr_addr,
	output tcw_pkg::tcw_cell_t mem_wr_data
);

	localparam int NCELLS = ROWS * COLS;
	localparam int CW     = $clog2(NCELLS + 1);
	localparam int COLW   = $clog2(COLS);
	localparam int IW     = CW + 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_FILL,
		ST_PUT,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		JOB_RESET,
		JOB_CLEAR,
		JOB_SCROLL
	} job_t;

	state_t          state_q;
	job_t            job_q;
	logic [AW-1:0]   a_q;
	logic [7:0]      fill_attr_q;
	logic [CW-1:0]   cursor_q;
	logic [COLW-1:0] col_q;
	logic [7:0]      chr_q;
	logic [7:0]      attr_q;
	logic            scr_q;
	logic            rd_ok_q;
	logic            wv_s1;
	logic [AW-1:0]   wa_s1;

	logic            accept;
	logic            at_end;
	logic            idx_ok;
	logic            put_now;
	logic            fill_we;
	logic [IW-1:0]   idx_ext;
	logic [IW-1:0]   cur_ext;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign at_end    = (cursor_q == CW'(NCELLS));
	assign idx_ext   = IW'(req.cell_index);
	assign idx_ok    = (idx_ext < IW'(NCELLS));
	assign put_now   = accept && (req.req_type == tcw_pkg::REQ_PUT)
		&& (req.char_code != tcw_pkg::NEWLINE_CODE) && !at_end;
	// The first fill cycle after a copy gives the write port to the last copied cell.
	assign fill_we   = (state_q == ST_FILL) && !wv_s1;
	assign cur_ext   = IW'(cursor_q);

	always_comb begin
		mem_rd_en   = (state_q == ST_COPY)
			|| (accept && (req.req_type == tcw_pkg::REQ_READ) && idx_ok);
		mem_rd_addr = (state_q == ST_COPY) ? AW'(a_q + COLS) : idx_ext[AW-1:0];
	end

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = cursor_q[AW-1:0];
		mem_wr_data = '{attr: req.attr, chr: req.char_code};
		if (wv_s1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = wa_s1;
			mem_wr_data = mem_rd_data;
		end else if (fill_we) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = a_q;
			mem_wr_data = '{attr: fill_attr_q, chr: tcw_pkg::SPACE_CODE};
		end else if (state_q == ST_PUT) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = AW'(NCELLS - COLS);
			mem_wr_data = '{attr: attr_q, chr: chr_q};
		end else if (put_now) begin
			mem_wr_en   = 1'b1;
		end
	end

	always_comb begin
		res_valid      = (state_q == ST_DONE);
		res.cursor_pos = cur_ext[10:0];
		res.read_char  = rd_ok_q ? mem_rd_data.chr : 8'd0;
		res.read_attr  = rd_ok_q ? mem_rd_data.attr : 8'd0;
		res.scrolled   = scr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			job_q       <= JOB_RESET;
			a_q         <= '0;
			fill_attr_q <= tcw_pkg::BLANK_ATTR_RST;
			cursor_q    <= '0;
			col_q       <= '0;
			chr_q       <= '0;
			attr_q      <= '0;
			scr_q       <= 1'b0;
			rd_ok_q     <= 1'b0;
			wv_s1       <= 1'b0;
			wa_s1       <= '0;
		end else begin
			wv_s1 <= (state_q == ST_COPY);
			wa_s1 <= a_q;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scr_q   <= 1'b0;
						rd_ok_q <= 1'b0;
						state_q <= ST_DONE;
						case (req.req_type)
							tcw_pkg::REQ_PUT: begin
								if (req.char_code == tcw_pkg::NEWLINE_CODE) begin
									if (!at_end) begin
										cursor_q <= cursor_q - CW'(col_q) + CW'(COLS);
										col_q    <= '0;
									end
								end else if (at_end) begin
									chr_q       <= req.char_code;
									attr_q      <= req.attr;
									job_q       <= JOB_SCROLL;
									fill_attr_q <= blank_attr;
									a_q         <= '0;
									state_q     <= ST_COPY;
								end else begin
									cursor_q <= cursor_q + CW'(1);
									col_q    <= (col_q == COLW'(COLS - 1)) ? '0 : col_q + COLW'(1);
								end
							end
							tcw_pkg::REQ_CLEAR: begin
								job_q       <= JOB_CLEAR;
								fill_attr_q <= blank_attr;
								a_q         <= '0;
								state_q     <= ST_FILL;
							end
							tcw_pkg::REQ_READ: begin
								rd_ok_q <= idx_ok;
							end
							default: begin
							end
						endcase
					end
				end
				ST_COPY: begin
					if (a_q == AW'(NCELLS - COLS - 1)) begin
						a_q     <= AW'(NCELLS - COLS);
						state_q <= ST_FILL;
					end else begin
						a_q <= a_q + AW'(1);
					end
				end
				ST_FILL: begin
					if (fill_we) begin
						if (a_q == AW'(NCELLS - 1)) begin
							case (job_q)
								JOB_RESET: begin
									state_q <= ST_IDLE;
								end
								JOB_CLEAR: begin
									cursor_q <= '0;
									col_q    <= '0;
									state_q  <= ST_DONE;
								end
								default: begin
									state_q <= ST_PUT;
								end
							endcase
						end else begin
							a_q <= a_q + AW'(1);
						end
					end
				end
				ST_PUT: begin
					cursor_q <= CW'(NCELLS - COLS + 1);
					col_q    <= COLW'(1);
					scr_q    <= 1'b1;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: src/text_console_writer.sv
// Text console of ROWS x COLS cells (character low byte, attribute high byte) held in one
// single-port-write memory with registered reads, with a cursor counted in cells. A put,
// newline, read or unused request goes from acceptance through the done state of the
// sequencer into the output register. A clear walks the write port over every cell; a put
// that has to scroll first copies each row up one cell per cycle, then blanks the bottom
// row and writes the character into its first cell. Both walks go cell by cell because of
// the single write port of the screen memory. After reset the screen memory is swept to
// blank cells with attribute 0x0F; no request is accepted during that sweep, while writes
// to the blank attribute register are taken at any time.
module text_console_writer #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  tcw_pkg::tcw_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tcw_pkg::tcw_rsp_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);

	localparam int AW = $clog2(ROWS * COLS);

	logic               res_valid;
	logic               res_ready;
	tcw_pkg::tcw_rsp_t  res;
	logic [7:0]         blank_attr_q;
	logic               out_valid_q;
	tcw_pkg::tcw_rsp_t  out_q;

	logic               mem_rd_en;
	logic [AW-1:0]      mem_rd_addr;
	tcw_pkg::tcw_cell_t mem_rd_data;
	logic               mem_wr_en;
	logic [AW-1:0]      mem_wr_addr;
	tcw_pkg::tcw_cell_t mem_wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_attr_q <= tcw_pkg::BLANK_ATTR_RST;
		end else if (cfg_valid) begin
			blank_attr_q <= cfg_data;
		end
	end

	// The output register takes a new result whenever the held one is gone or leaving.
	assign res_ready = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	tcw_seq #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.blank_attr  (blank_attr_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	tcw_screen_ram #(
		.DEPTH (ROWS * COLS)
	) u_ram (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

endmodule

FILE: src/tcw_checker.sv
module tcw_checker #(
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int COLS = tcw_pkg::COLS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input tcw_pkg::tcw_rsp_t rsp
);

	localparam int NCELLS = ROWS * COLS;

	// A stalled response transaction keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// Requests are handled one at a time, so acceptance is always followed by a busy cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted on consecutive cycles");

	// The cursor saturates at the end of the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (NCELLS > 2047) || (32'(rsp.cursor_pos) <= NCELLS))
		else $error("cursor beyond the end of the screen");

	// A scroll leaves the cursor just after the first cell of the bottom row, and no read data.
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.scrolled |->
			rsp.cursor_pos == 11'(NCELLS - COLS + 1) && rsp.read_char == 8'd0
			&& rsp.read_attr == 8'd0)
		else $error("scroll response inconsistent");

endmodule

bind text_console_writer tcw_checker #(
	.ROWS (ROWS),
	.COLS (COLS)
) u_tcw_checker (.*);
